// File: design/rne_pkg.sv
package rne_pkg;

	localparam int VALUE_W  = 12;
	localparam int LETTER_W = 7;
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 8;

	localparam logic [LETTER_W-1:0] LETTER_I = 7'h49;
	localparam logic [LETTER_W-1:0] LETTER_V = 7'h56;
	localparam logic [LETTER_W-1:0] LETTER_X = 7'h58;
	localparam logic [LETTER_W-1:0] LETTER_L = 7'h4C;
	localparam logic [LETTER_W-1:0] LETTER_C = 7'h43;
	localparam logic [LETTER_W-1:0] LETTER_D = 7'h44;
	localparam logic [LETTER_W-1:0] LETTER_M = 7'h4D;

	// decimal places, most significant first
	localparam logic [1:0] PLACE_THOU = 2'd0;
	localparam logic [1:0] PLACE_HUND = 2'd1;
	localparam logic [1:0] PLACE_TENS = 2'd2;
	localparam logic [1:0] PLACE_UNIT = 2'd3;

	typedef struct packed {
		logic [2:0] thou;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] unit;
	} rne_digits_t;

	localparam int DIGITS_W = $bits(rne_digits_t);

	function automatic logic [VALUE_W-1:0] thou_base(input logic [2:0] th);
		case (th)
			3'd0:    thou_base = 12'd0;
			3'd1:    thou_base = 12'd1000;
			3'd2:    thou_base = 12'd2000;
			3'd3:    thou_base = 12'd3000;
			3'd4:    thou_base = 12'd4000;
			default: thou_base = 12'd0;
		endcase
	endfunction

	function automatic logic [9:0] hund_base(input logic [3:0] h);
		case (h)
			4'd0:    hund_base = 10'd0;
			4'd1:    hund_base = 10'd100;
			4'd2:    hund_base = 10'd200;
			4'd3:    hund_base = 10'd300;
			4'd4:    hund_base = 10'd400;
			4'd5:    hund_base = 10'd500;
			4'd6:    hund_base = 10'd600;
			4'd7:    hund_base = 10'd700;
			4'd8:    hund_base = 10'd800;
			4'd9:    hund_base = 10'd900;
			default: hund_base = 10'd0;
		endcase
	endfunction

	function automatic logic [6:0] tens_base(input logic [3:0] t);
		case (t)
			4'd0:    tens_base = 7'd0;
			4'd1:    tens_base = 7'd10;
			4'd2:    tens_base = 7'd20;
			4'd3:    tens_base = 7'd30;
			4'd4:    tens_base = 7'd40;
			4'd5:    tens_base = 7'd50;
			4'd6:    tens_base = 7'd60;
			4'd7:    tens_base = 7'd70;
			4'd8:    tens_base = 7'd80;
			4'd9:    tens_base = 7'd90;
			default: tens_base = 7'd0;
		endcase
	endfunction

	// number of letters a digit gives at its place
	function automatic logic [2:0] digit_len(input logic [1:0] place, input logic [3:0] d);
		if (place == PLACE_THOU) begin
			digit_len = d[2:0];
		end else begin
			case (d)
				4'd1:    digit_len = 3'd1;
				4'd2:    digit_len = 3'd2;
				4'd3:    digit_len = 3'd3;
				4'd4:    digit_len = 3'd2;
				4'd5:    digit_len = 3'd1;
				4'd6:    digit_len = 3'd2;
				4'd7:    digit_len = 3'd3;
				4'd8:    digit_len = 3'd4;
				4'd9:    digit_len = 3'd2;
				default: digit_len = 3'd0;
			endcase
		end
	endfunction

	// letter at position pos within the letters of one digit
	function automatic logic [LETTER_W-1:0] digit_letter(input logic [1:0] place,
			input logic [3:0] d, input logic [2:0] pos);
		logic [LETTER_W-1:0] one;
		logic [LETTER_W-1:0] five;
		logic [LETTER_W-1:0] ten;
		case (place)
			PLACE_HUND: begin
				one = LETTER_C; five = LETTER_D; ten = LETTER_M;
			end
			PLACE_TENS: begin
				one = LETTER_X; five = LETTER_L; ten = LETTER_C;
			end
			default: begin
				one = LETTER_I; five = LETTER_V; ten = LETTER_X;
			end
		endcase
		if (place == PLACE_THOU) begin
			digit_letter = LETTER_M;
		end else if (d == 4'd9) begin
			digit_letter = (pos == 3'd0) ? one : ten;
		end else if (d == 4'd4) begin
			digit_letter = (pos == 3'd0) ? one : five;
		end else if (d >= 4'd5) begin
			digit_letter = (pos == 3'd0) ? five : one;
		end else begin
			digit_letter = one;
		end
	endfunction

endpackage

// File: design/rne_front.sv
module rne_front
	import rne_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [VALUE_W-1:0]  in_value,
	output logic                push,
	input  logic                q_full,
	output rne_digits_t         push_digits
);

	logic              v_s1, v_s2, v_s3;
	logic [2:0]        th_s1, th_s2;
	logic [9:0]        r1_s1;
	logic [3:0]        h_s2;
	logic [6:0]        r2_s2;
	rne_digits_t       dig_s3;

	logic              adv;
	logic [2:0]        th_c;
	logic [VALUE_W-1:0] r1_wide;
	logic [15:0]       prod_h;
	logic [3:0]        h_c;
	logic [9:0]        r2_wide;
	logic [14:0]       prod_t;
	logic [3:0]        t_c;
	logic [6:0]        u_wide;

	// whole pipe moves together, held only when the queue cannot take the head
	assign adv      = !(v_s3 && q_full);
	assign in_ready = adv;

	always_comb begin
		if (in_value >= 12'd4000)      th_c = 3'd4;
		else if (in_value >= 12'd3000) th_c = 3'd3;
		else if (in_value >= 12'd2000) th_c = 3'd2;
		else if (in_value >= 12'd1000) th_c = 3'd1;
		else                           th_c = 3'd0;
	end
	assign r1_wide = in_value - thou_base(th_c);

	// r1 / 100 as r1 * 41 >> 12, exact below 1000
	assign prod_h  = {6'd0, r1_s1} * 16'd41;
	assign h_c     = prod_h[15:12];
	assign r2_wide = r1_s1 - hund_base(h_c);

	// r2 / 10 as r2 * 205 >> 11, exact below 100
	assign prod_t  = {8'd0, r2_s2} * 15'd205;
	assign t_c     = prod_t[14:11];
	assign u_wide  = r2_s2 - tens_base(t_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			th_s1       <= th_c;
			r1_s1       <= r1_wide[9:0];
			th_s2       <= th_s1;
			h_s2        <= h_c;
			r2_s2       <= r2_wide[6:0];
			dig_s3.thou <= th_s2;
			dig_s3.hund <= h_s2;
			dig_s3.tens <= t_c;
			dig_s3.unit <= u_wide[3:0];
		end
	end

	// a zero value makes no letters and never enters the queue
	assign push        = v_s3 && adv && (dig_s3 != '0);
	assign push_digits = dig_s3;

endmodule

// File: design/rne_fifo.sv
module rne_fifo
	import rne_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  rne_digits_t push_digits,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output rne_digits_t head
);

	rne_digits_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_digits;
	end

endmodule

// File: design/rne_back.sv
module rne_back
	import rne_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_not_empty,
	input  rne_digits_t          q_head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [LETTER_W-1:0]  out_letter,
	output logic                 out_last
);

	rne_digits_t          dig_q;
	logic [3:0]           mask_q;
	logic [2:0]           pos_q;
	logic                 out_valid_q;
	logic [LETTER_W-1:0]  out_letter_q;
	logic                 out_last_q;

	logic                 adv;
	logic                 emit;
	logic [1:0]           place;
	logic [3:0]           place_bit;
	logic [3:0]           cur_digit;
	logic [2:0]           len;
	logic                 digit_done;
	logic                 last_now;
	logic                 load;

	// first place still holding letters, thousands first
	always_comb begin
		if (mask_q[0]) begin
			place = PLACE_THOU; place_bit = 4'b0001; cur_digit = {1'b0, dig_q.thou};
		end else if (mask_q[1]) begin
			place = PLACE_HUND; place_bit = 4'b0010; cur_digit = dig_q.hund;
		end else if (mask_q[2]) begin
			place = PLACE_TENS; place_bit = 4'b0100; cur_digit = dig_q.tens;
		end else begin
			place = PLACE_UNIT; place_bit = 4'b1000; cur_digit = dig_q.unit;
		end
	end

	assign len        = digit_len(place, cur_digit);
	assign digit_done = (pos_q == len - 3'd1);
	assign last_now   = digit_done && ((mask_q & ~place_bit) == 4'd0);

	assign adv  = !out_valid_q || out_ready;
	assign emit = adv && (mask_q != 4'd0);
	assign load = q_not_empty && ((mask_q == 4'd0) || (emit && last_now));
	assign pop  = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= 4'd0;
			pos_q       <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) out_valid_q <= emit;
			if (load) begin
				mask_q <= {q_head.unit != 4'd0, q_head.tens != 4'd0,
					q_head.hund != 4'd0, q_head.thou != 3'd0};
				pos_q  <= 3'd0;
			end else if (emit) begin
				if (digit_done) begin
					mask_q <= mask_q & ~place_bit;
					pos_q  <= 3'd0;
				end else begin
					pos_q  <= pos_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) dig_q <= q_head;
		if (emit) begin
			out_letter_q <= digit_letter(place, cur_digit, pos_q);
			out_last_q   <= last_now;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_letter = out_letter_q;
	assign out_last   = out_last_q;

endmodule

// File: design/binary_to_roman_numeral_encoder.sv
// Roman numeral encoder. Each input word carries a 12-bit unsigned value in s_tdata[11:0];
// the block returns its numeral as one ASCII letter per output word, thousands first, with
// tlast on the final letter. A value of zero produces no output words, and 4000 to 4095
// start with four M letters. A three-stage front pipe splits the value into decimal digits
// and hands them through a two-entry queue to the letter sequencer, so input words are taken
// back to back until the queue fills. The output runs at one letter per cycle while m_tready
// is high, and the next numeral follows the last letter with no gap when its digits are already
// queued, so a value yields 1 to 15 letters and that output sequencer sets the sustained rate.
// The first letter of a value passes through the front pipe, the queue and the letter register.
module binary_to_roman_numeral_encoder
	import rne_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // [11:0] value, [15:12] zero
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // [6:0] letter, [7] zero
	output logic                m_tlast
);

	logic                push;
	logic                q_full;
	logic                q_not_empty;
	logic                pop;
	rne_digits_t         push_digits;
	rne_digits_t         q_head;
	logic [LETTER_W-1:0] letter;

	rne_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_value    (s_tdata[VALUE_W-1:0]),
		.push        (push),
		.q_full      (q_full),
		.push_digits (push_digits)
	);

	rne_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_digits (push_digits),
		.full        (q_full),
		.pop         (pop),
		.not_empty   (q_not_empty),
		.head        (q_head)
	);

	rne_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_letter  (letter),
		.out_last    (m_tlast)
	);

	assign m_tdata = {1'b0, letter};

endmodule

// File: design/rne_checker.sv
module rne_checker
	import rne_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	a_letter_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] == LETTER_I || m_tdata[6:0] == LETTER_V ||
			m_tdata[6:0] == LETTER_X || m_tdata[6:0] == LETTER_L ||
			m_tdata[6:0] == LETTER_C || m_tdata[6:0] == LETTER_D ||
			m_tdata[6:0] == LETTER_M))
		else $error("output is not a numeral letter");

	// pad bit above the letter stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[7])
		else $error("output pad bit set");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(s_tvalid && s_tready) && !$past(m_tvalid) && !$past(s_tvalid, 2) &&
		!$past(s_tvalid, 3) && !$past(s_tvalid, 4) && !$past(s_tvalid, 5) &&
		!$past(s_tvalid, 6) &&
		!$past(m_tvalid, 2) && !$past(m_tvalid, 3) && !$past(m_tvalid, 4) &&
		!$past(m_tvalid, 5) && !$past(m_tvalid, 6) |-> !m_tvalid)
		else $error("output word without any input word");

endmodule

bind binary_to_roman_numeral_encoder rne_checker u_rne_checker (.*);
